>>> hw/rtl/mqbrb_pkg.sv
package mqbrb_pkg;

  // default sizing of the bank
  localparam int NUM_QUEUES_DEF = 4;
  localparam int DEPTH_DEF      = 512;

  // fixed field widths
  localparam int QID_W  = 2;
  localparam int DATA_W = 8;
  localparam int FREE_W = 9;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

>>> hw/rtl/mqbrb_byte_ram.sv
module mqbrb_byte_ram #(
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  mqbrb_pkg::byte_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output mqbrb_pkg::byte_t  rdata
);

  mqbrb_pkg::byte_t mem [2**AW];
  mqbrb_pkg::byte_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/mqbrb_ptr_store.sv
module mqbrb_ptr_store #(
  parameter int NUM_QUEUES = mqbrb_pkg::NUM_QUEUES_DEF,
  parameter int PW         = 9,
  parameter int QW         = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          re,
  input  logic [QW-1:0] raddr,
  input  logic          we,
  input  logic [QW-1:0] waddr,
  input  logic [PW-1:0] whead,
  input  logic [PW-1:0] wtail,
  output logic [PW-1:0] rhead,
  output logic [PW-1:0] rtail
);

  logic [2*PW-1:0]       mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] valid_r;
  logic [2*PW-1:0]       rdata_r;
  logic                  rvalid_r;

  // pointer pair memory, head in the upper half
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {whead, wtail};
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // per-queue written flags stand in for the reset of the pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= valid_r[raddr];
      end
    end
  end

  // a queue never written reads as both pointers at zero
  assign rhead = rvalid_r ? rdata_r[2*PW-1:PW] : '0;
  assign rtail = rvalid_r ? rdata_r[PW-1:0]    : '0;

endmodule

>>> hw/rtl/multi_queue_byte_ring_buffer.sv
// channel | ports                                   | handshake
// --------+-----------------------------------------+-------------------------------
// request | in_func, in_queue_id, in_data           | taken when start & !busy
// result  | out_ok, out_read_data, out_is_empty,    | out_valid high for one cycle,
//         | out_is_full, out_free_slots             | taken at the edge ending it
//
// Each request runs through pointer memory read, byte memory access with
// pointer write-back, then the result register load. busy is high from
// acceptance until the result register is loaded, so a new request is taken
// only once the last one is through; the registered reads of both memories set this.
// Synchronous active-low reset clears the control state and the pointer
// valid flags; no clearing pass is needed. The receiver cannot stall results.
module multi_queue_byte_ring_buffer #(
  parameter int NUM_QUEUES = mqbrb_pkg::NUM_QUEUES_DEF,
  parameter int DEPTH      = mqbrb_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [mqbrb_pkg::QID_W-1:0]   in_queue_id,
  input  mqbrb_pkg::byte_t              in_data,
  output logic                          out_valid,
  output logic                          out_ok,
  output mqbrb_pkg::byte_t              out_read_data,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  output logic [mqbrb_pkg::FREE_W-1:0]  out_free_slots
);

  localparam int PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QNUM_W  = $clog2(NUM_QUEUES + 1);
  localparam int QCMP_W  = (mqbrb_pkg::QID_W > QNUM_W) ? mqbrb_pkg::QID_W : QNUM_W;
  localparam int FREE_XW = (PW > mqbrb_pkg::FREE_W) ? PW : mqbrb_pkg::FREE_W;
  localparam int AW      = QW + PW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PTR  = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  logic [1:0]       state_r, state_nxt;
  logic             accept;
  logic [QCMP_W-1:0] qid_ext;
  logic [QW-1:0]    qidx_in;
  logic             qvalid_in;

  // latched request
  logic             func_r;
  logic [QW-1:0]    qidx_r;
  logic             qvalid_r;
  mqbrb_pkg::byte_t data_r;

  // pointer access
  logic [PW-1:0]    head_q, tail_q;
  logic [PW-1:0]    nt, nh;
  logic             enq_ok, deq_ok;
  logic [PW-1:0]    head_new, tail_new;
  logic             ptr_we;
  logic [PW-1:0]    head_new_r, tail_new_r;
  logic             ok_r;

  // byte memory
  mqbrb_pkg::byte_t ram_rdata;

  // occupancy
  logic [PW:0]      diff;
  logic [PW:0]      cnt_ext;
  logic [PW-1:0]    cnt;
  logic [PW-1:0]    freec;
  logic [FREE_XW-1:0] free_ext;

  // result registers
  logic                         out_valid_r;
  logic                         out_ok_r;
  mqbrb_pkg::byte_t             out_read_data_r;
  logic                         out_is_empty_r;
  logic                         out_is_full_r;
  logic [mqbrb_pkg::FREE_W-1:0] out_free_slots_r;

  // request decode
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign qid_ext   = QCMP_W'(in_queue_id);
  assign qidx_in   = qid_ext[QW-1:0];
  assign qvalid_in = (qid_ext < QCMP_W'(NUM_QUEUES));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PTR;
        end
      end
      S_PTR:   state_nxt = S_CALC;
      S_CALC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_CALC);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      qidx_r   <= qidx_in;
      qvalid_r <= qvalid_in;
      data_r   <= in_data;
    end
  end

  mqbrb_ptr_store #(
    .NUM_QUEUES (NUM_QUEUES),
    .PW         (PW),
    .QW         (QW)
  ) u_ptr_store (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept && qvalid_in),
    .raddr (qidx_in),
    .we    (ptr_we),
    .waddr (qidx_r),
    .whead (head_new),
    .wtail (tail_new),
    .rhead (head_q),
    .rtail (tail_q)
  );

  // ring advance and full / empty tests
  assign nt       = (tail_q == LAST_SLOT) ? '0 : tail_q + PW'(1);
  assign nh       = (head_q == LAST_SLOT) ? '0 : head_q + PW'(1);
  assign enq_ok   = qvalid_r && (func_r == mqbrb_pkg::FUNC_ENQ) && (nt != head_q);
  assign deq_ok   = qvalid_r && (func_r == mqbrb_pkg::FUNC_DEQ) && (head_q != tail_q);
  assign head_new = deq_ok ? nh : head_q;
  assign tail_new = enq_ok ? nt : tail_q;
  assign ptr_we   = (state_r == S_PTR) && (enq_ok || deq_ok);

  mqbrb_byte_ram #(
    .AW (AW)
  ) u_byte_ram (
    .clk   (clk),
    .we    ((state_r == S_PTR) && enq_ok),
    .waddr ({qidx_r, nt}),
    .wdata (data_r),
    .re    ((state_r == S_PTR) && deq_ok),
    .raddr ({qidx_r, nh}),
    .rdata (ram_rdata)
  );

  // updated pointers for the occupancy step
  always_ff @(posedge clk) begin
    if (state_r == S_PTR) begin
      head_new_r <= head_new;
      tail_new_r <= tail_new;
      ok_r       <= enq_ok || deq_ok;
    end
  end

  // bytes held, modulo the ring size
  assign diff     = {1'b0, tail_new_r} - {1'b0, head_new_r};
  assign cnt_ext  = diff[PW] ? diff + (PW+1)'(DEPTH) : diff;
  assign cnt      = cnt_ext[PW-1:0];
  assign freec    = LAST_SLOT - cnt;
  assign free_ext = FREE_XW'(freec);

  // result load
  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      if (!qvalid_r) begin
        out_ok_r         <= 1'b0;
        out_read_data_r  <= '0;
        out_is_empty_r   <= 1'b1;
        out_is_full_r    <= 1'b0;
        out_free_slots_r <= '0;
      end else begin
        out_ok_r         <= ok_r;
        out_read_data_r  <= (ok_r && (func_r == mqbrb_pkg::FUNC_DEQ)) ? ram_rdata : '0;
        out_is_empty_r   <= (cnt == '0);
        out_is_full_r    <= (freec == '0);
        out_free_slots_r <= free_ext[mqbrb_pkg::FREE_W-1:0];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_data  = out_read_data_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_is_full    = out_is_full_r;
  assign out_free_slots = out_free_slots_r;

  // a result strobe only follows the occupancy step
  a_strobe_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_CALC))
    else $error("result strobe without a finished request");

  // a successful enqueue leaves the queue non-empty
  a_enq_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok && (func_r == mqbrb_pkg::FUNC_ENQ)) |-> !out_is_empty)
    else $error("queue empty after a successful enqueue");

  // a successful dequeue leaves the queue not full
  a_deq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ok && (func_r == mqbrb_pkg::FUNC_DEQ)) |-> !out_is_full)
    else $error("queue full after a successful dequeue");

  // a refused request returns no byte
  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_data == '0))
    else $error("byte returned for a refused request");

endmodule

>>> tb/multi_queue_byte_ring_buffer_tb.sv
`timescale 1ns / 1ps

typedef logic [mqbrb_pkg::QID_W-1:0]  qid_t;
typedef logic [mqbrb_pkg::FREE_W-1:0] free_t;

// status returned for one word, in port order
typedef struct packed {
  logic             ok;
  mqbrb_pkg::byte_t read_data;
  logic             is_empty;
  logic             is_full;
  free_t            free_slots;
} fifo_status_t;

// predicts the status of every word and checks the returned ones in order
class fifo_bank_model;
  int unsigned      head_ptr [mqbrb_pkg::NUM_QUEUES_DEF];
  int unsigned      tail_ptr [mqbrb_pkg::NUM_QUEUES_DEF];
  mqbrb_pkg::byte_t ring_bytes [mqbrb_pkg::NUM_QUEUES_DEF][mqbrb_pkg::DEPTH_DEF];
  fifo_status_t     pending_status [$];
  int               errors;
  int               words_noted;
  int               words_checked;
  int               full_refusals;
  int               empty_refusals;

  function new();
    foreach (head_ptr[i]) begin
      head_ptr[i] = 0;
      tail_ptr[i] = 0;
    end
    errors         = 0;
    words_noted    = 0;
    words_checked  = 0;
    full_refusals  = 0;
    empty_refusals = 0;
  endfunction

  function int unsigned bytes_held(int unsigned q);
    return (tail_ptr[q] + mqbrb_pkg::DEPTH_DEF - head_ptr[q]) % mqbrb_pkg::DEPTH_DEF;
  endfunction

  // pointers advance before the slot is used, so one slot always stays free
  function void note_request(logic f, qid_t q, mqbrb_pkg::byte_t d);
    fifo_status_t st;
    int unsigned  nxt;
    int unsigned  held;
    st = '0;
    words_noted++;
    // absent queue index reads as an empty queue with nothing free
    if (q >= mqbrb_pkg::NUM_QUEUES_DEF) begin
      st.is_empty = 1'b1;
      pending_status.push_back(st);
      return;
    end
    if (f == mqbrb_pkg::FUNC_ENQ) begin
      nxt = (tail_ptr[q] + 1) % mqbrb_pkg::DEPTH_DEF;
      if (nxt != head_ptr[q]) begin
        ring_bytes[q][nxt] = d;
        tail_ptr[q]        = nxt;
        st.ok              = 1'b1;
      end else begin
        full_refusals++;
      end
    end else begin
      if (head_ptr[q] != tail_ptr[q]) begin
        nxt          = (head_ptr[q] + 1) % mqbrb_pkg::DEPTH_DEF;
        st.read_data = ring_bytes[q][nxt];
        head_ptr[q]  = nxt;
        st.ok        = 1'b1;
      end else begin
        empty_refusals++;
      end
    end
    held          = bytes_held(q);
    st.is_empty   = (held == 0);
    st.is_full    = (held == mqbrb_pkg::DEPTH_DEF - 1);
    st.free_slots = free_t'(mqbrb_pkg::DEPTH_DEF - 1 - held);
    pending_status.push_back(st);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(fifo_status_t got);
    fifo_status_t want;
    if (pending_status.size() == 0) begin
      $error("status returned with no word outstanding");
      errors++;
      return;
    end
    want = pending_status.pop_front();
    words_checked++;
    compare_field("ok", 32'(want.ok), 32'(got.ok));
    compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
    compare_field("free_slots", 32'(want.free_slots), 32'(got.free_slots));
  endfunction
endclass

module multi_queue_byte_ring_buffer_tb;

  localparam int STALL_LIMIT = 200;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic              in_func     = mqbrb_pkg::FUNC_ENQ;
  qid_t              in_queue_id = '0;
  mqbrb_pkg::byte_t  in_data     = '0;
  logic              busy;
  logic              out_valid;
  logic              out_ok;
  mqbrb_pkg::byte_t  out_read_data;
  logic              out_is_empty;
  logic              out_is_full;
  free_t             out_free_slots;
  fifo_status_t      seen_status;

  fifo_bank_model    bank;
  bit                idle_on     = 1'b1;
  int                stall_cycles = 0;

  multi_queue_byte_ring_buffer #(
    .NUM_QUEUES(mqbrb_pkg::NUM_QUEUES_DEF),
    .DEPTH     (mqbrb_pkg::DEPTH_DEF)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_queue_id   (in_queue_id),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_read_data (out_read_data),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_free_slots(out_free_slots)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign seen_status = {out_ok, out_read_data, out_is_empty, out_is_full, out_free_slots};

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      bank.check_result(seen_status);
    end
  end

  // watchdog on cycles with no word or status moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("multi_queue_byte_ring_buffer_tb failed");
      $finish;
    end
  end

  // drive one word, waiting out a random gap first while idling is on
  task automatic send_word(input logic f, input qid_t q, input mqbrb_pkg::byte_t d);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 5)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= f;
    in_queue_id <= q;
    in_data     <= d;
    do @(posedge clk); while (busy);
    bank.note_request(f, q, d);
    // switch idling on and off in stretches
    if (bank.words_noted % 40 == 0) begin
      idle_on = ($urandom_range(0, 3) != 0);
    end
  endtask

  // mixed traffic over all queues
  task automatic send_mixed(input int n, input int push_pct);
    logic f;
    repeat (n) begin
      f = ($urandom_range(0, 99) < push_pct) ? mqbrb_pkg::FUNC_ENQ : mqbrb_pkg::FUNC_DEQ;
      send_word(f, qid_t'($urandom_range(0, mqbrb_pkg::NUM_QUEUES_DEF - 1)),
                mqbrb_pkg::byte_t'($urandom));
    end
  endtask

  // fill one queue past full, then drain it past empty, with some cross traffic
  task automatic fill_and_drain(input int unsigned q);
    while (bank.bytes_held(q) < mqbrb_pkg::DEPTH_DEF - 1) begin
      if ($urandom_range(0, 9) == 0) begin
        send_mixed(1, 50);
      end else begin
        send_word(mqbrb_pkg::FUNC_ENQ, qid_t'(q), mqbrb_pkg::byte_t'($urandom));
      end
    end
    repeat (4) send_word(mqbrb_pkg::FUNC_ENQ, qid_t'(q), mqbrb_pkg::byte_t'($urandom));
    while (bank.bytes_held(q) > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_mixed(1, 50);
      end else begin
        send_word(mqbrb_pkg::FUNC_DEQ, qid_t'(q), mqbrb_pkg::byte_t'($urandom));
      end
    end
    repeat (3) send_word(mqbrb_pkg::FUNC_DEQ, qid_t'(q), mqbrb_pkg::byte_t'($urandom));
  endtask

  initial begin
    bank = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // pops on empty queues after reset
    for (int q = 0; q < mqbrb_pkg::NUM_QUEUES_DEF; q++) begin
      send_word(mqbrb_pkg::FUNC_DEQ, qid_t'(q), 8'hFF);
    end
    // extreme and alternating bytes in, then out again
    send_word(mqbrb_pkg::FUNC_ENQ, 2'd0, 8'h00);
    send_word(mqbrb_pkg::FUNC_ENQ, 2'd0, 8'hFF);
    send_word(mqbrb_pkg::FUNC_ENQ, 2'd1, 8'hA5);
    send_word(mqbrb_pkg::FUNC_ENQ, 2'd2, 8'h5A);
    send_word(mqbrb_pkg::FUNC_ENQ, 2'd3, 8'hFF);
    send_word(mqbrb_pkg::FUNC_DEQ, 2'd0, 8'h00);
    send_word(mqbrb_pkg::FUNC_DEQ, 2'd0, 8'h00);
    send_word(mqbrb_pkg::FUNC_DEQ, 2'd0, 8'h00);
    for (int q = 1; q < mqbrb_pkg::NUM_QUEUES_DEF; q++) begin
      send_word(mqbrb_pkg::FUNC_DEQ, qid_t'(q), 8'h00);
    end

    // random traffic, with one queue taken to full and back
    send_mixed(80, 50);
    fill_and_drain($urandom_range(0, mqbrb_pkg::NUM_QUEUES_DEF - 1));
    send_mixed(80, 60);

    start <= 1'b0;
    while (bank.pending_status.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("%0d words driven across %0d queues, %0d status words checked",
             bank.words_noted, mqbrb_pkg::NUM_QUEUES_DEF, bank.words_checked);
    $display("%0d pushes refused on a full queue, %0d pops refused on an empty one",
             bank.full_refusals, bank.empty_refusals);
    if (bank.errors == 0) begin
      $display("multi_queue_byte_ring_buffer_tb passed");
    end else begin
      $display("multi_queue_byte_ring_buffer_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mqbrb_pkg.sv
hw/rtl/mqbrb_byte_ram.sv
hw/rtl/mqbrb_ptr_store.sv
hw/rtl/multi_queue_byte_ring_buffer.sv
tb/multi_queue_byte_ring_buffer_tb.sv
